FILE: hw/rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants for the timestamp batch sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package tbs_pkg;
    localparam int CAPACITY = 64;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TIME_W = 63;
    localparam int PAY_W = 64;
    localparam int TOT_W = 64;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic [PAY_W-1:0]  hit_payload;
        logic              batch_end;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0] out_time;
        logic [PAY_W-1:0]  out_payload;
        logic              out_last;
        logic [TOT_W-1:0]  hits_passed;
        logic              overflow;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0] key;
        logic [PAY_W-1:0]  pay;
    } t_hit;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_DROP  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_DFLSH = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_hit    hit;
    } t_cmd;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;
endpackage
`default_nettype wire

FILE: hw/rtl/timestamp_batch_sorter.sv
// Output: after the flagged last hit is accepted, results follow one per cycle, the last flagged.
// Throughput: one hit per cycle while loading; busy after the last hit until the drain ends.
// Receiver cannot stall; results appear for one cycle on o_strobe.
// Reset: synchronous active low; clears counts, flags and the running total.
// ----------------------------------------------------------------------------
// timestamp_batch_sorter
// Stable insertion sorter for batches of timestamped hits.
// ----------------------------------------------------------------------------
`default_nettype none
module timestamp_batch_sorter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire tbs_pkg::t_in i_data,
    output logic              o_strobe,
    output tbs_pkg::t_out     o_data
);
    logic          q_push, q_full, q_valid, q_pop, fdone;
    tbs_pkg::t_cmd q_in, q_out;

    tbs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_data(i_data),
        .i_q_full(q_full), .i_flush_done(fdone), .o_busy(busy),
        .o_q_push(q_push), .o_q_cmd(q_in)
    );

    tbs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_cmd(q_in),
        .i_pop(q_pop), .o_full(q_full), .o_valid(q_valid), .o_cmd(q_out)
    );

    tbs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_out),
        .o_pop(q_pop), .o_flush_done(fdone), .o_strobe(o_strobe), .o_data(o_data)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/tbs_front.sv
// ----------------------------------------------------------------------------
// tbs_front
// Classifies incoming hits into store, drop and flush commands.
// ----------------------------------------------------------------------------
`default_nettype none
module tbs_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire tbs_pkg::t_in       i_data,
    input  wire logic               i_q_full,
    input  wire logic               i_flush_done,
    output logic                    o_busy,
    output logic                    o_q_push,
    output tbs_pkg::t_cmd           o_q_cmd
);
    logic [tbs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_wait, n_wait;
    logic                      acc, full;

    assign o_busy = r_wait || i_q_full;
    assign acc = i_start && !o_busy;
    assign full = (r_cnt == tbs_pkg::CNT_W'(tbs_pkg::CAPACITY));

    always_comb begin
        n_cnt = r_cnt;
        n_wait = r_wait;
        o_q_push = acc;
        o_q_cmd.hit.key = i_data.hit_time;
        o_q_cmd.hit.pay = i_data.hit_payload;
        o_q_cmd.op = tbs_pkg::CMD_STORE;
        if (r_wait && i_flush_done) begin
            n_wait = 1'b0;
        end
        if (acc) begin
            if (i_data.batch_end) begin
                o_q_cmd.op = full ? tbs_pkg::CMD_DFLSH : tbs_pkg::CMD_FLUSH;
                n_cnt = '0;
                n_wait = 1'b1;
            end else begin
                o_q_cmd.op = full ? tbs_pkg::CMD_DROP : tbs_pkg::CMD_STORE;
                if (!full) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wait <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_wait <= n_wait;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tbs_pkg::CNT_W'(tbs_pkg::CAPACITY))
        else $error("fill count out of range");
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> o_busy) else $error("accepting during drain");
    a_end_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.batch_end) |=> r_wait) else $error("flush not held");
endmodule
`default_nettype wire

FILE: hw/rtl/tbs_queue.sv
// ----------------------------------------------------------------------------
// tbs_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module tbs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tbs_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output tbs_pkg::t_cmd      o_cmd
);
    localparam int PW = $clog2(tbs_pkg::QDEPTH);
    tbs_pkg::t_cmd          r_mem [tbs_pkg::QDEPTH];
    logic [PW-1:0]          r_wp, r_rp;
    logic [PW:0]            r_cnt;
    logic                   pu, po;

    assign o_full = (r_cnt == (PW+1)'(tbs_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_mem[r_rp];
    assign pu = i_push && !o_full;
    assign po = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (pu) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (pu) r_wp <= r_wp + 1'b1;
            if (po) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(pu) - (PW+1)'(po);
        end
    end

    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(tbs_pkg::QDEPTH)) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_valid) else $error("empty queue valid");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pu && !po) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("count step");
endmodule
`default_nettype wire

FILE: hw/rtl/tbs_back.sv
// ----------------------------------------------------------------------------
// tbs_back
// Systolic insertion chain; stores hits in order and drains on flush.
// ----------------------------------------------------------------------------
`default_nettype none
module tbs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tbs_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_flush_done,
    output logic               o_strobe,
    output tbs_pkg::t_out      o_data
);
    localparam int N = tbs_pkg::CAPACITY;
    logic [N-1:0]              r_vld, n_vld;
    logic [tbs_pkg::TOT_W-1:0] r_tot, n_tot;
    logic                      r_drop, n_drop;
    tbs_pkg::t_state           r_st, n_st;
    logic                      shift_in, shift_out;
    logic [N-1:0]              gt;
    logic                      r_stb, n_stb;
    tbs_pkg::t_out             r_out, n_out;

    // Hold keys ascending from cell 0; insert after the last key not above the new one.
    for (genvar k = 0; k < N; k++) begin : g_cell
        tbs_pkg::t_hit r_hit;
        tbs_pkg::t_hit up_hit;
        tbs_pkg::t_hit dn_hit;
        logic          prev_gt;

        if (k == N - 1) begin : g_top
            assign up_hit = r_hit;
        end else begin : g_mid
            assign up_hit = g_cell[k+1].r_hit;
        end

        if (k == 0) begin : g_bot
            assign prev_gt = 1'b0;
            assign dn_hit = i_cmd.hit;
        end else begin : g_upper
            assign prev_gt = gt[k-1];
            assign dn_hit = g_cell[k-1].r_hit;
        end

        assign gt[k] = r_vld[k] && (r_hit.key > i_cmd.hit.key);

        always_ff @(posedge i_clk) begin
            if (shift_out) begin
                r_hit <= up_hit;
            end else if (shift_in) begin
                if (prev_gt) begin
                    r_hit <= dn_hit;
                end else if (!r_vld[k] || gt[k]) begin
                    r_hit <= i_cmd.hit;
                end
            end
        end
    end

    always_comb begin
        n_st = r_st;
        n_vld = r_vld;
        n_tot = r_tot;
        n_drop = r_drop;
        n_stb = 1'b0;
        n_out = r_out;
        o_pop = 1'b0;
        o_flush_done = 1'b0;
        shift_in = 1'b0;
        shift_out = 1'b0;
        case (r_st)
            tbs_pkg::ST_LOAD: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        tbs_pkg::CMD_STORE: begin
                            shift_in = 1'b1;
                            n_vld = {r_vld[N-2:0], 1'b1};
                        end
                        tbs_pkg::CMD_DROP: n_drop = 1'b1;
                        tbs_pkg::CMD_FLUSH: begin
                            shift_in = 1'b1;
                            n_vld = {r_vld[N-2:0], 1'b1};
                            n_st = tbs_pkg::ST_DRAIN;
                        end
                        tbs_pkg::CMD_DFLSH: begin
                            n_drop = 1'b1;
                            n_st = tbs_pkg::ST_DRAIN;
                        end
                        default: n_st = r_st;
                    endcase
                end
            end
            tbs_pkg::ST_DRAIN: begin
                shift_out = 1'b1;
                n_vld = {1'b0, r_vld[N-1:1]};
                n_stb = 1'b1;
                n_tot = r_tot + 1'b1;
                n_out.out_time = g_cell[0].r_hit.key;
                n_out.out_payload = g_cell[0].r_hit.pay;
                n_out.out_last = !r_vld[1];
                n_out.hits_passed = r_tot + 1'b1;
                n_out.overflow = r_drop;
                if (!r_vld[1]) begin
                    n_st = tbs_pkg::ST_LOAD;
                    n_drop = 1'b0;
                    o_flush_done = 1'b1;
                end
            end
            default: n_st = tbs_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tbs_pkg::ST_LOAD;
            r_vld <= '0;
            r_tot <= '0;
            r_drop <= 1'b0;
            r_stb <= 1'b0;
        end else begin
            r_st <= n_st;
            r_vld <= n_vld;
            r_tot <= n_tot;
            r_drop <= n_drop;
            r_stb <= n_stb;
        end
    end

    assign o_strobe = r_stb;
    assign o_data = r_out;

    a_vld_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld & (r_vld + 1'b1)) == '0)) else $error("chain not packed");
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tbs_pkg::ST_DRAIN) |-> r_vld[0]) else $error("empty drain");
    a_tot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_stb |-> (n_tot == r_tot + 1'b1)) else $error("total step");
endmodule
`default_nettype wire
